/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros shared by the label encoder RTL.
// Both macros sample on the rising edge of clk and are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that an implication or expression holds at every clock edge.
`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never occurs.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

/* src/dnle_pkg.sv */
// ----------------------------------------------------------------------------
// dnle_pkg
// Shared constants and controller/datapath interface types for the
// DNS name label encoder.
// ----------------------------------------------------------------------------
package dnle_pkg;

    localparam int LABEL_MAX = 62;
    localparam int CNT_W     = 6;
    localparam int BYTE_W    = 8;

    localparam logic [BYTE_W-1:0] DOT_CHAR  = 8'h2E;
    localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

    // Operation codes of an input transaction
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic store;      // accept a label character
        logic start;      // accept a dot or end of name, latch the label
        logic emit_len;   // load the length byte into the output register
        logic emit_char;  // load the next stored character
        logic emit_term;  // load the zero terminator
    } dnle_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_flush;   // the offered input ends a label
        logic out_free;   // the output register can take a byte this cycle
        logic len_zero;   // the latched label is empty
        logic ptr_last;   // the read pointer is at the final character
        logic end_run;    // the run closes the name with a terminator
    } dnle_sts_t;

endpackage

/* src/dnle_ctrl.sv */
// ----------------------------------------------------------------------------
// dnle_ctrl
// Controller state machine: accepts input transactions in idle and sequences
// the length byte, the stored characters and, at end of name, the terminator.
// ----------------------------------------------------------------------------
module dnle_ctrl
    import dnle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  dnle_sts_t sts,
    output dnle_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LEN   = 4'b0010,
        ST_CHARS = 4'b0100,
        ST_TERM  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (sts.is_flush)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_LEN;
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                    end
                end
            end
            ST_LEN:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_len = 1'b1;
                    if (!sts.len_zero)
                        state_next = ST_CHARS;
                    else if (sts.end_run)
                        state_next = ST_TERM;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_CHARS:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_char = 1'b1;
                    if (sts.ptr_last)
                        state_next = sts.end_run ? ST_TERM : ST_IDLE;
                end
            end
            ST_TERM:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_term = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* src/dnle_dp.sv */
// ----------------------------------------------------------------------------
// dnle_dp
// Datapath: label buffer memory, fill count, overflow flag, read pointer and
// the output register that drives the result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dnle_dp
    import dnle_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              operation,
    input  logic [BYTE_W-1:0] char_in,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [BYTE_W-1:0] out_byte,
    output logic              last,
    output logic              overflow,
    input  dnle_cmd_t         cmd,
    output dnle_sts_t         sts
);

    logic [BYTE_W-1:0] mem [LABEL_MAX];

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  len_reg;
    logic              end_reg;
    logic              run_ovf_reg;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  ptr_inc;
    logic [BYTE_W-1:0] rd_data_reg;

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              last_reg;
    logic              ovf_out_reg;

    logic              load;
    logic              cnt_full;
    logic [BYTE_W-1:0] byte_next;
    logic              last_next;

    assign cnt_full = (cnt_reg == CNT_W'(LABEL_MAX));
    assign ptr_inc  = ptr_reg + CNT_W'(1);
    assign load     = cmd.emit_len | cmd.emit_char | cmd.emit_term;

    // Report status to the controller
    assign sts.is_flush = (operation == OP_END) || (char_in == DOT_CHAR);
    assign sts.out_free = !out_valid_reg || out_ready;
    assign sts.len_zero = (len_reg == '0);
    assign sts.ptr_last = (ptr_inc == len_reg);
    assign sts.end_run  = end_reg;

    // Update fill count and overflow flag; a flush empties the label
    always_comb
    begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (cmd.store)
        begin
            if (cnt_full)
                ovf_next = 1'b1;
            else
                cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (cmd.start)
        begin
            cnt_next = '0;
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

    // Latch the label length, run kind and overflow when a flush starts
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            len_reg     <= cnt_reg;
            end_reg     <= operation;
            run_ovf_reg <= ovf_reg;
        end
    end

    // Advance the read pointer as characters leave
    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.start)
            ptr_next = '0;
        else if (cmd.emit_char)
            ptr_next = ptr_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ptr_reg <= '0;
        else
            ptr_reg <= ptr_next;
    end

    // Label buffer: write on store, registered read at the next pointer
    always_ff @(posedge clk)
    begin
        if (cmd.store && !cnt_full)
            mem[cnt_reg] <= char_in;
        if (ptr_next < CNT_W'(LABEL_MAX))
            rd_data_reg <= mem[ptr_next];
    end

    // Select the byte to load into the output register
    always_comb
    begin
        byte_next = ZERO_BYTE;
        last_next = 1'b1;
        if (cmd.emit_len)
        begin
            byte_next = BYTE_W'(len_reg);
            last_next = !end_reg && sts.len_zero;
        end
        else if (cmd.emit_char)
        begin
            byte_next = rd_data_reg;
            last_next = !end_reg && sts.ptr_last;
        end
    end

    // Output register: hold until the transaction completes
    assign out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= byte_next;
            last_reg     <= last_next;
            ovf_out_reg  <= run_ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;
    assign overflow  = ovf_out_reg;

    // Checks
    `ASSERT_NEVER(a_cnt_range, cnt_reg > CNT_W'(LABEL_MAX), "label count above limit")
    `ASSERT_PROP(a_load_free, load |-> sts.out_free, "output loaded while occupied")
    `ASSERT_PROP(a_ptr_in_label, cmd.emit_char |-> (ptr_reg < len_reg), "read past label")
    `ASSERT_PROP(a_start_clears, cmd.start |=> (cnt_reg == '0) && !ovf_reg, "flush left label")

endmodule

/* src/dns_name_label_encoder.sv */
// ----------------------------------------------------------------------------
// dns_name_label_encoder
// Converts a dotted host name, one character per transaction, into DNS wire
// format labels: length byte, label characters, and a zero terminator.
//
//   Channel  Handshake           Payload
//   input    in_valid/in_ready   operation, char_in
//   output   out_valid/out_ready out_byte, last, overflow
//
// A label character is written into the label buffer; a dot or end of name
// is accepted, then one byte per cycle (length, n characters, terminator
// at end of name) follows unless stalled, set by the single buffer read port.
// Input is taken only while the controller is idle; the output register lets
// the last byte of a run wait while the next input is accepted.
// A stalled output holds the run in place; reset empties the label.
// ----------------------------------------------------------------------------
module dns_name_label_encoder
    import dnle_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              operation,
    input  logic [BYTE_W-1:0] char_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              last,
    output logic              overflow
);

    dnle_cmd_t cmd;
    dnle_sts_t sts;

    // Sequence each flush
    dnle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Store and emit label bytes
    dnle_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .operation (operation),
        .char_in   (char_in),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .last      (last),
        .overflow  (overflow),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
